[rtl/afp_pkg.sv]
// Shared types and constants for the aim frame parser.
// Holds the frame marker bytes, parser phase codes and the per-byte result record.
// No dependencies.
package afp_pkg;

    localparam int FRAME_BYTES = 13;
    localparam int IDX_W       = 4;

    localparam logic [7:0] SOF0_BYTE = 8'hAA;
    localparam logic [7:0] SOF1_BYTE = 8'hBB;
    localparam logic [7:0] SOF2_BYTE = 8'hCC;
    localparam logic [7:0] EOF_BYTE  = 8'hFF;

    localparam logic [IDX_W-1:0] IDX_SOF1     = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_SOF2     = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_PAY_FIRST = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_PAY_LAST = IDX_W'(10);
    localparam logic [IDX_W-1:0] IDX_CHECK    = IDX_W'(11);
    localparam logic [IDX_W-1:0] IDX_TAIL     = IDX_W'(FRAME_BYTES - 1);

    localparam logic [1:0] PHASE_HUNT   = 2'd0;
    localparam logic [1:0] PHASE_HEADER = 2'd1;
    localparam logic [1:0] PHASE_BODY   = 2'd2;

    typedef struct packed {
        logic               byte_accepted;
        logic               frame_done;
        logic signed [15:0] pitch_centideg;
        logic signed [15:0] yaw_centideg;
        logic [7:0]         target_set;
        logic [3:0]         target_count;
        logic [1:0]         target_colour;
        logic               shoot_request;
        logic [7:0]         aim_x;
        logic [7:0]         aim_y;
    } result_t;

endpackage

[rtl/afp_tracker.sv]
// Frame tracking state machine for the aim frame parser.
// Keeps the parse phase, byte index, payload bytes and running checksum.
// Depends on afp_pkg.
module afp_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        rx_byte,
    output afp_pkg::result_t  result
);

    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic [afp_pkg::IDX_W-1:0] index_reg;
    logic [afp_pkg::IDX_W-1:0] index_next;
    logic [7:0]              data_reg [8];
    logic [7:0]              check_reg;
    logic [7:0]              xor_reg;
    logic [2:0]              pay_offset;
    logic                    store_payload;
    logic                    store_check;
    logic                    frame_good;

    assign pay_offset    = 3'(index_reg - afp_pkg::IDX_PAY_FIRST);
    assign store_payload = (phase_reg == afp_pkg::PHASE_BODY)
                           && (index_reg >= afp_pkg::IDX_PAY_FIRST)
                           && (index_reg <= afp_pkg::IDX_PAY_LAST);
    assign store_check   = (phase_reg == afp_pkg::PHASE_BODY)
                           && (index_reg == afp_pkg::IDX_CHECK);
    assign frame_good    = (rx_byte == afp_pkg::EOF_BYTE) && (check_reg == xor_reg);

    always_comb
    begin
        phase_next           = afp_pkg::PHASE_HUNT;
        index_next           = '0;
        result               = '0;
        case (phase_reg)
            afp_pkg::PHASE_HUNT:
            begin
                if (rx_byte == afp_pkg::SOF0_BYTE)
                begin
                    phase_next           = afp_pkg::PHASE_HEADER;
                    index_next           = afp_pkg::IDX_SOF1;
                    result.byte_accepted = 1'b1;
                end
            end
            afp_pkg::PHASE_HEADER:
            begin
                if (rx_byte == afp_pkg::SOF1_BYTE && index_reg == afp_pkg::IDX_SOF1)
                begin
                    phase_next           = afp_pkg::PHASE_HEADER;
                    index_next           = afp_pkg::IDX_SOF2;
                    result.byte_accepted = 1'b1;
                end
                else if (rx_byte == afp_pkg::SOF2_BYTE && index_reg == afp_pkg::IDX_SOF2)
                begin
                    phase_next           = afp_pkg::PHASE_BODY;
                    index_next           = afp_pkg::IDX_PAY_FIRST;
                    result.byte_accepted = 1'b1;
                end
            end
            afp_pkg::PHASE_BODY:
            begin
                if (index_reg == afp_pkg::IDX_TAIL)
                begin
                    if (frame_good)
                    begin
                        result.byte_accepted  = 1'b1;
                        result.frame_done     = 1'b1;
                        result.pitch_centideg = {data_reg[0], data_reg[1]};
                        result.yaw_centideg   = {data_reg[2], data_reg[3]};
                        result.target_set     = data_reg[4];
                        result.target_count   = data_reg[5][7:4];
                        result.target_colour  = data_reg[5][3:2];
                        result.shoot_request  = data_reg[5][0];
                        result.aim_x          = data_reg[6];
                        result.aim_y          = data_reg[7];
                    end
                end
                else
                begin
                    phase_next           = afp_pkg::PHASE_BODY;
                    index_next           = index_reg + afp_pkg::IDX_W'(1);
                    result.byte_accepted = 1'b1;
                end
            end
            default:
            begin
                phase_next = afp_pkg::PHASE_HUNT;
                index_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= afp_pkg::PHASE_HUNT;
            index_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store_payload)
        begin
            data_reg[pay_offset] <= rx_byte;
            if (index_reg == afp_pkg::IDX_PAY_FIRST)
            begin
                xor_reg <= rx_byte;
            end
            else
            begin
                xor_reg <= xor_reg ^ rx_byte;
            end
        end
        if (take && store_check)
        begin
            check_reg <= rx_byte;
        end
    end

endmodule

[rtl/aim_frame_parser.sv]
// Top level of the aim frame parser: byte input channel, tracker and result register.
// Depends on afp_pkg and afp_tracker.
//
// Usage: one received serial byte is offered per transfer on in_valid/in_ready with
// rx_byte. Every accepted byte yields exactly one result transfer on out_valid/out_ready.
// byte_accepted tells whether the byte fit the frame so far; frame_done marks the byte
// that completed a frame with header AA BB CC, correct XOR checksum and FF tail, and
// only then do the decoded fields carry the payload (they read zero otherwise).
// Results are registered: the result of a byte accepted at one edge is presented from
// the next cycle. Throughput is one byte per cycle, set by the single result register;
// in_ready stays high while that register is empty or being drained in the same cycle.
// When the receiver stalls, the result is held and in_ready drops until it is taken.
// Reset empties the result register and returns the tracker to hunting for AA.
module aim_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               byte_accepted,
    output logic               frame_done,
    output logic signed [15:0] pitch_centideg,
    output logic signed [15:0] yaw_centideg,
    output logic [7:0]         target_set,
    output logic [3:0]         target_count,
    output logic [1:0]         target_colour,
    output logic               shoot_request,
    output logic [7:0]         aim_x,
    output logic [7:0]         aim_y
);

    afp_pkg::result_t result;
    afp_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             take;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    afp_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_accepted  = out_reg.byte_accepted;
    assign frame_done     = out_reg.frame_done;
    assign pitch_centideg = out_reg.pitch_centideg;
    assign yaw_centideg   = out_reg.yaw_centideg;
    assign target_set     = out_reg.target_set;
    assign target_count   = out_reg.target_count;
    assign target_colour  = out_reg.target_colour;
    assign shoot_request  = out_reg.shoot_request;
    assign aim_x          = out_reg.aim_x;
    assign aim_y          = out_reg.aim_y;

endmodule
